// ===== hw/rtl/prc_pkg.sv =====
// Shared constants, register codes and types for the particle color ramp.
package prc_pkg;

  // Field widths of the stream items and the configuration port.
  localparam int AGE_W   = 16;
  localparam int LIFE_W  = 16;
  localparam int COLOR_W = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = COLOR_W / CH_W;
  localparam int MID_W   = 17;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = 3;

  // Default fraction width of the ramp position.
  localparam int FRAC_BITS_DEF = 16;

  // The mid point register is a Q0.16 fraction.
  localparam int MID_FRAC_W = 16;

  // Register indexes (byte address divided by four).
  localparam logic [IDX_W-1:0] REG_START_HEAD = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_TAIL = 3'd1;
  localparam logic [IDX_W-1:0] REG_MID_HEAD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MID_TAIL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_HEAD   = 3'd4;
  localparam logic [IDX_W-1:0] REG_END_TAIL   = 3'd5;
  localparam logic [IDX_W-1:0] REG_MID_POINT  = 3'd6;

  // Reset values of the registers.
  localparam logic [COLOR_W-1:0] COLOR_RESET = 32'h8080_8080;
  localparam logic [MID_W-1:0]   MID_RESET   = 17'h1_FFFF;

  // Flags that travel with an item through the rescale divider.
  typedef struct packed {
    logic full;   // rescaled position is exactly 1.0
    logic lower;  // position lies in the start-to-mid half
  } prc_flags_t;

endpackage

// ===== hw/rtl/prc_div_cell.sv =====
// One restoring division step with its own pipeline register and handshake.
module prc_div_cell #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [QW-1:0] quot_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW:0]   rem_o,
  output logic [DW-1:0] div_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] div_q;
  logic [QW-1:0] quot_q, quot_d;
  logic [SW-1:0] side_q;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // The partial remainder stays below the divisor, so its top bit can be dropped.
  always_comb begin
    shifted = {rem_i[DW-1:0], 1'b0};
    ge      = shifted >= {1'b0, div_i};
    diff    = shifted - {1'b0, div_i};
    rem_d   = ge ? diff : shifted;
    quot_d  = {quot_i[QW-2:0], ge};
  end

  // The stage takes a new item whenever it is empty or its item moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      quot_q <= quot_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quot_o  = quot_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/prc_split.sv =====
// Picks the ramp half from the life fraction and sets up the rescale division.
module prc_split #(
  parameter int FB = prc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [FB-1:0]               quot_i,
  input  logic                        sat_i,
  input  logic [prc_pkg::MID_W-1:0]   mid_point_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [FB-1:0]               num_o,
  output logic [FB:0]                 den_o,
  output prc_pkg::prc_flags_t         flags_o
);

  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic                valid_q;
  logic [FB-1:0]       num_q, num_d;
  logic [FB:0]         den_q, den_d;
  prc_pkg::prc_flags_t flags_q, flags_d;
  logic [FB-1:0]       mid_scaled;
  logic [FB:0]         frac;
  logic                mid_en;

  // Bring the Q0.16 mid point to the fraction width; a right shift truncates.
  if (FB >= prc_pkg::MID_FRAC_W) begin : g_mid_up
    assign mid_scaled = FB'(mid_point_i[prc_pkg::MID_FRAC_W-1:0]) << (FB - prc_pkg::MID_FRAC_W);
  end else begin : g_mid_down
    assign mid_scaled = FB'(mid_point_i[prc_pkg::MID_FRAC_W-1:0] >> (prc_pkg::MID_FRAC_W - FB));
  end

  // Select the half and form the numerator and divisor of the rescale.
  always_comb begin
    mid_en        = !mid_point_i[prc_pkg::MID_W-1];
    frac          = sat_i ? ONE : {1'b0, quot_i};
    flags_d.lower = mid_en && (frac < {1'b0, mid_scaled});
    flags_d.full  = frac[FB];
    if (flags_d.lower) begin
      num_d = frac[FB-1:0];
      den_d = {1'b0, mid_scaled};
    end else if (mid_en) begin
      num_d = frac[FB-1:0] - mid_scaled;
      den_d = ONE - {1'b0, mid_scaled};
    end else begin
      num_d = frac[FB-1:0];
      den_d = ONE;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      num_q   <= num_d;
      den_q   <= den_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

// ===== hw/rtl/prc_blend.sv =====
// Blends the eight color channels by the rescaled position into the output register.
module prc_blend #(
  parameter int FB = prc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [FB-1:0]               quot_i,
  input  prc_pkg::prc_flags_t         flags_i,
  input  logic                        mid_en_i,
  input  logic [prc_pkg::COLOR_W-1:0] start_head_i,
  input  logic [prc_pkg::COLOR_W-1:0] start_tail_i,
  input  logic [prc_pkg::COLOR_W-1:0] mid_head_i,
  input  logic [prc_pkg::COLOR_W-1:0] mid_tail_i,
  input  logic [prc_pkg::COLOR_W-1:0] end_head_i,
  input  logic [prc_pkg::COLOR_W-1:0] end_tail_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [prc_pkg::COLOR_W-1:0] head_rgba_o,
  output logic [prc_pkg::COLOR_W-1:0] tail_rgba_o
);

  localparam int          CW    = prc_pkg::CH_W;
  localparam int          NCH   = prc_pkg::NUM_CH;
  localparam int          PW    = FB + 1 + CW;
  localparam logic [FB:0] ONE   = {1'b1, {FB{1'b0}}};

  logic                           valid_q;
  logic [prc_pkg::COLOR_W-1:0]    head_q, tail_q;
  logic [2*prc_pkg::COLOR_W-1:0]  from_all, to_all, res_all;
  logic [FB:0]                    pos;
  logic                           upper;

  // Choose the color pair of the active half of the ramp.
  always_comb begin
    upper    = mid_en_i && !flags_i.lower;
    pos      = flags_i.full ? ONE : {1'b0, quot_i};
    from_all = upper ? {mid_tail_i, mid_head_i} : {start_tail_i, start_head_i};
    to_all   = flags_i.lower ? {mid_tail_i, mid_head_i} : {end_tail_i, end_head_i};
  end

  // One lane per channel: start plus the truncated signed step, wrapping mod 256.
  for (genvar ln = 0; ln < 2 * NCH; ln++) begin : g_lane
    logic [CW-1:0] a, b, mag, q;
    logic          neg;
    logic [PW-1:0] prod;
    always_comb begin
      a    = from_all[ln*CW +: CW];
      b    = to_all[ln*CW +: CW];
      neg  = b < a;
      mag  = neg ? (a - b) : (b - a);
      prod = PW'(mag) * PW'(pos);
      q    = prod[FB +: CW];
    end
    assign res_all[ln*CW +: CW] = neg ? (a - q) : (a + q);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      head_q <= res_all[prc_pkg::COLOR_W-1:0];
      tail_q <= res_all[2*prc_pkg::COLOR_W-1:prc_pkg::COLOR_W];
    end
  end

  assign valid_o     = valid_q;
  assign head_rgba_o = head_q;
  assign tail_rgba_o = tail_q;

endmodule

// ===== hw/rtl/particle_color_ramp.sv =====
// Particle color ramp: life fraction divider, half select, rescale divider, blend.
// Items pass the life divider cells, split register, rescale divider cells, blend register.
// Throughput: one item per cycle unless the output stalls; every stage of the two divider
// chains takes one quotient bit and can pass its item on in the cycle it takes a new one.
// Reset clears all stage valid bits; color registers reset to 0x80808080, mid_point to -1.
// No clearing pass is needed after reset.
module particle_color_ramp #(
  parameter int FRAC_BITS = prc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input items.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // [15:0] age, [31:16] lifetime
  // Result items.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,   // [31:0] head_rgba, [63:32] tail_rgba
  // Register port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prc_pkg::ADDR_W-1:0]  paddr,
  input  logic [prc_pkg::DATA_W-1:0]  pwdata,
  output logic [prc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int FB    = FRAC_BITS;
  localparam int LW    = prc_pkg::LIFE_W;
  localparam int FLG_W = $bits(prc_pkg::prc_flags_t);

  // Configuration registers.
  logic [prc_pkg::COLOR_W-1:0] start_head_q, start_tail_q, mid_head_q, mid_tail_q;
  logic [prc_pkg::COLOR_W-1:0] end_head_q, end_tail_q;
  logic [prc_pkg::MID_W-1:0]   mid_point_q;
  logic                        cfg_wr;
  logic [prc_pkg::IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[prc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= prc_pkg::COLOR_RESET;
      start_tail_q <= prc_pkg::COLOR_RESET;
      mid_head_q   <= prc_pkg::COLOR_RESET;
      mid_tail_q   <= prc_pkg::COLOR_RESET;
      end_head_q   <= prc_pkg::COLOR_RESET;
      end_tail_q   <= prc_pkg::COLOR_RESET;
      mid_point_q  <= prc_pkg::MID_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        prc_pkg::REG_START_HEAD: start_head_q <= pwdata;
        prc_pkg::REG_START_TAIL: start_tail_q <= pwdata;
        prc_pkg::REG_MID_HEAD:   mid_head_q   <= pwdata;
        prc_pkg::REG_MID_TAIL:   mid_tail_q   <= pwdata;
        prc_pkg::REG_END_HEAD:   end_head_q   <= pwdata;
        prc_pkg::REG_END_TAIL:   end_tail_q   <= pwdata;
        prc_pkg::REG_MID_POINT:  mid_point_q  <= pwdata[prc_pkg::MID_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back; the mid point is sign extended.
  always_comb begin
    case (cfg_idx)
      prc_pkg::REG_START_HEAD: prdata = start_head_q;
      prc_pkg::REG_START_TAIL: prdata = start_tail_q;
      prc_pkg::REG_MID_HEAD:   prdata = mid_head_q;
      prc_pkg::REG_MID_TAIL:   prdata = mid_tail_q;
      prc_pkg::REG_END_HEAD:   prdata = end_head_q;
      prc_pkg::REG_END_TAIL:   prdata = end_tail_q;
      prc_pkg::REG_MID_POINT:
        prdata = {{(prc_pkg::DATA_W - prc_pkg::MID_W){mid_point_q[prc_pkg::MID_W-1]}},
                  mid_point_q};
      default: prdata = '0;
    endcase
  end

  // Life fraction divider: age * 2^FB / lifetime, one bit per cell.
  // When age reaches lifetime (or lifetime is zero) the fraction saturates at 1.0.
  logic          v1   [FB+1];
  logic          rdy1 [FB+1];
  logic [LW:0]   rem1 [FB+1];
  logic [LW-1:0] div1 [FB+1];
  logic [FB-1:0] quo1 [FB+1];
  logic [0:0]    sat1 [FB+1];

  assign v1[0]         = s_axis_tvalid;
  assign s_axis_tready = rdy1[0];
  assign rem1[0]       = {1'b0, s_axis_tdata[prc_pkg::AGE_W-1:0]};
  assign div1[0]       = s_axis_tdata[prc_pkg::AGE_W +: LW];
  assign quo1[0]       = '0;
  assign sat1[0]       = s_axis_tdata[prc_pkg::AGE_W-1:0] >= s_axis_tdata[prc_pkg::AGE_W +: LW];

  for (genvar k = 0; k < FB; k++) begin : g_life_div
    prc_div_cell #(.DW(LW), .QW(FB), .SW(1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v1[k]),
      .ready_o (rdy1[k]),
      .rem_i   (rem1[k]),
      .div_i   (div1[k]),
      .quot_i  (quo1[k]),
      .side_i  (sat1[k]),
      .valid_o (v1[k+1]),
      .ready_i (rdy1[k+1]),
      .rem_o   (rem1[k+1]),
      .div_o   (div1[k+1]),
      .quot_o  (quo1[k+1]),
      .side_o  (sat1[k+1])
    );
  end

  // Half select and rescale setup.
  logic                v2   [FB+1];
  logic                rdy2 [FB+1];
  logic [FB+1:0]       rem2 [FB+1];
  logic [FB:0]         div2 [FB+1];
  logic [FB-1:0]       quo2 [FB+1];
  logic [FLG_W-1:0]    flg2 [FB+1];
  logic [FB-1:0]       split_num;
  prc_pkg::prc_flags_t split_flags;

  prc_split #(.FB(FB)) u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1[FB]),
    .ready_o     (rdy1[FB]),
    .quot_i      (quo1[FB]),
    .sat_i       (sat1[FB][0]),
    .mid_point_i (mid_point_q),
    .valid_o     (v2[0]),
    .ready_i     (rdy2[0]),
    .num_o       (split_num),
    .den_o       (div2[0]),
    .flags_o     (split_flags)
  );

  assign rem2[0] = {2'b00, split_num};
  assign quo2[0] = '0;
  assign flg2[0] = split_flags;

  // Rescale divider: position within the chosen half, one bit per cell.
  for (genvar k = 0; k < FB; k++) begin : g_half_div
    prc_div_cell #(.DW(FB + 1), .QW(FB), .SW(FLG_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v2[k]),
      .ready_o (rdy2[k]),
      .rem_i   (rem2[k]),
      .div_i   (div2[k]),
      .quot_i  (quo2[k]),
      .side_i  (flg2[k]),
      .valid_o (v2[k+1]),
      .ready_i (rdy2[k+1]),
      .rem_o   (rem2[k+1]),
      .div_o   (div2[k+1]),
      .quot_o  (quo2[k+1]),
      .side_o  (flg2[k+1])
    );
  end

  // Color blend and output register.
  logic [prc_pkg::COLOR_W-1:0] head_rgba, tail_rgba;

  prc_blend #(.FB(FB)) u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (v2[FB]),
    .ready_o      (rdy2[FB]),
    .quot_i       (quo2[FB]),
    .flags_i      (prc_pkg::prc_flags_t'(flg2[FB])),
    .mid_en_i     (!mid_point_q[prc_pkg::MID_W-1]),
    .start_head_i (start_head_q),
    .start_tail_i (start_tail_q),
    .mid_head_i   (mid_head_q),
    .mid_tail_i   (mid_tail_q),
    .end_head_i   (end_head_q),
    .end_tail_i   (end_tail_q),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .head_rgba_o  (head_rgba),
    .tail_rgba_o  (tail_rgba)
  );

  assign m_axis_tdata = {tail_rgba, head_rgba};

  // With no result waiting, every stage can move, so the input side must be open.
  a_open_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while the output register is empty");

  // The rescale divisor is never zero.
  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2[0] |-> (div2[0] != '0))
    else $error("rescale divisor is zero");

  // The lower half is only taken when a mid point is set.
  a_lower_needs_mid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2[0] && split_flags.lower) |-> !mid_point_q[prc_pkg::MID_W-1])
    else $error("lower half chosen without a mid point");

  // A position in the lower half can never be the full 1.0.
  a_lower_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2[0] && split_flags.lower) |-> !split_flags.full)
    else $error("lower half item marked as full scale");

endmodule

// ===== bench/tb_particle_color_ramp.sv =====
// Self-checking testbench for the particle color ramp, with its color predictor.
`timescale 1ns / 100ps

module tb_particle_color_ramp;

  // Fraction width of the ramp position used by the block and the predictor.
  localparam int FRAC = prc_pkg::FRAC_BITS_DEF;
  localparam bit [63:0] ONE_Q = 64'd1 << FRAC;
  localparam int MID_UP = (FRAC > prc_pkg::MID_FRAC_W) ? FRAC - prc_pkg::MID_FRAC_W : 0;
  localparam int MID_DOWN = (FRAC < prc_pkg::MID_FRAC_W) ? prc_pkg::MID_FRAC_W - FRAC : 0;
  // An index past the register file; writes to it must change nothing.
  localparam logic [prc_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [prc_pkg::MID_W-1:0] MID_NONE = prc_pkg::MID_RESET;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int DRAIN_CYCLES = 2 * FRAC + 8;

  typedef struct {
    bit [prc_pkg::COLOR_W-1:0] head;
    bit [prc_pkg::COLOR_W-1:0] tail;
  } ramp_colors_t;

  // Predicts the head and tail colors of each particle and checks the block's results.
  class color_ramp_checker;
    bit [prc_pkg::COLOR_W-1:0] start_head, start_tail, mid_head, mid_tail, end_head, end_tail;
    bit [prc_pkg::MID_W-1:0] mid_raw;
    ramp_colors_t pending_colors[$];
    int errors;
    int particles;
    int reg_writes;

    function new();
      start_head = prc_pkg::COLOR_RESET;
      start_tail = prc_pkg::COLOR_RESET;
      mid_head = prc_pkg::COLOR_RESET;
      mid_tail = prc_pkg::COLOR_RESET;
      end_head = prc_pkg::COLOR_RESET;
      end_tail = prc_pkg::COLOR_RESET;
      mid_raw = prc_pkg::MID_RESET;
      errors = 0;
      particles = 0;
      reg_writes = 0;
    endfunction

    function void load_reg(logic [prc_pkg::IDX_W-1:0] idx, logic [prc_pkg::DATA_W-1:0] value);
      reg_writes++;
      case (idx)
        prc_pkg::REG_START_HEAD: start_head = value;
        prc_pkg::REG_START_TAIL: start_tail = value;
        prc_pkg::REG_MID_HEAD: mid_head = value;
        prc_pkg::REG_MID_TAIL: mid_tail = value;
        prc_pkg::REG_END_HEAD: end_head = value;
        prc_pkg::REG_END_TAIL: end_tail = value;
        prc_pkg::REG_MID_POINT: mid_raw = value[prc_pkg::MID_W-1:0];
        default: ;
      endcase
    endfunction

    // Per channel: start + sign(d) * floor(|d| * pos), wrapping in eight bits.
    function bit [prc_pkg::COLOR_W-1:0] blend_color(bit [prc_pkg::COLOR_W-1:0] from,
                                                    bit [prc_pkg::COLOR_W-1:0] to,
                                                    bit [63:0] pos);
      bit [prc_pkg::COLOR_W-1:0] res;
      bit [prc_pkg::CH_W-1:0] a, b, q;
      bit [63:0] mag;
      res = '0;
      for (int ch = 0; ch < prc_pkg::NUM_CH; ch++) begin
        a = from[ch*prc_pkg::CH_W +: prc_pkg::CH_W];
        b = to[ch*prc_pkg::CH_W +: prc_pkg::CH_W];
        mag = (b < a) ? 64'(a - b) : 64'(b - a);
        q = prc_pkg::CH_W'((mag * pos) >> FRAC);
        res[ch*prc_pkg::CH_W +: prc_pkg::CH_W] = (b < a) ? a - q : a + q;
      end
      return res;
    endfunction

    function void note_particle(bit [prc_pkg::AGE_W-1:0] age, bit [prc_pkg::LIFE_W-1:0] life);
      bit [63:0] pos, m;
      bit [prc_pkg::COLOR_W-1:0] h0, h1, t0, t1;
      ramp_colors_t expected;
      h0 = start_head;
      t0 = start_tail;
      h1 = end_head;
      t1 = end_tail;
      // Life fraction, saturating at 1.0; a zero lifetime counts as fully aged.
      if (life == 0) begin
        pos = ONE_Q;
      end else begin
        pos = (64'(age) << FRAC) / 64'(life);
        if (pos > ONE_Q) pos = ONE_Q;
      end
      // A set mid point picks a half and rescales the position within it.
      if (!mid_raw[prc_pkg::MID_W-1]) begin
        m = (64'(mid_raw[prc_pkg::MID_FRAC_W-1:0]) << MID_UP) >> MID_DOWN;
        if (pos < m) begin
          h1 = mid_head;
          t1 = mid_tail;
          pos = (pos << FRAC) / m;
        end else begin
          h0 = mid_head;
          t0 = mid_tail;
          pos = ((pos - m) << FRAC) / (ONE_Q - m);
        end
      end
      expected.head = blend_color(h0, h1, pos);
      expected.tail = blend_color(t0, t1, pos);
      pending_colors.push_back(expected);
      particles++;
    endfunction

    function void check_colors(bit [prc_pkg::COLOR_W-1:0] head, bit [prc_pkg::COLOR_W-1:0] tail);
      ramp_colors_t expected;
      if (pending_colors.size() == 0) begin
        $error("result item with no particle pending: head_rgba %h tail_rgba %h", head, tail);
        errors++;
      end else begin
        expected = pending_colors.pop_front();
        if (head !== expected.head) begin
          $error("head_rgba mismatch: expected %h, actual %h", expected.head, head);
          errors++;
        end
        if (tail !== expected.tail) begin
          $error("tail_rgba mismatch: expected %h, actual %h", expected.tail, tail);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_colors.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [15:0] age, [31:16] lifetime
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;  // [31:0] head_rgba, [63:32] tail_rgba
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [prc_pkg::ADDR_W-1:0] paddr = '0;
  logic [prc_pkg::DATA_W-1:0] pwdata = '0;
  logic [prc_pkg::DATA_W-1:0] prdata;
  logic pready;

  bit quiet = 1'b0;
  int settings = 0;
  color_ramp_checker ramp_sb;

  particle_color_ramp #(.FRAC_BITS(FRAC)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one, none in quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: alternate runs of ready and stalls of random length.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 8) : $urandom_range(20, 60))
        @(negedge clk_i);
    end
  end

  // Every accepted result item is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      ramp_sb.check_colors(m_axis_tdata[31:0], m_axis_tdata[63:32]);
    end
  end

  // Register write: setup cycle, then access cycle; starts and ends at a falling edge.
  task automatic write_reg(input logic [prc_pkg::IDX_W-1:0] idx,
                           input logic [prc_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ramp_sb.load_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offers one particle after a random gap and returns at the falling edge after acceptance.
  task automatic send_particle(input logic [prc_pkg::AGE_W-1:0] age,
                               input logic [prc_pkg::LIFE_W-1:0] life);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {life, age};
    do @(posedge clk_i); while (!s_axis_tready);
    ramp_sb.note_particle(age, life);
    @(negedge clk_i);
  endtask

  // Stops the input stream and waits until every predicted color has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (ramp_sb.pending() > 0) @(negedge clk_i);
  endtask

  // A fresh ramp setting: extreme or random colors and a mid point of every kind.
  task automatic random_setting();
    logic [prc_pkg::DATA_W-1:0] color;
    logic [prc_pkg::MID_W-1:0] mid;
    int r;
    for (int i = 0; i <= prc_pkg::REG_END_TAIL; i++) begin
      r = $urandom_range(0, 99);
      color = (r < 15) ? 32'h0 : (r < 30) ? 32'hFFFF_FFFF : $urandom;
      write_reg(i[prc_pkg::IDX_W-1:0], color);
    end
    r = $urandom_range(0, 99);
    if (r < 20) mid = MID_NONE;
    else if (r < 30) mid = {1'b1, 16'($urandom)};
    else if (r < 40) mid = '0;
    else if (r < 50) mid = 17'h0_FFFF;
    else mid = {1'b0, 16'($urandom)};
    write_reg(prc_pkg::REG_MID_POINT, {15'($urandom), mid});
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
    settings++;
  endtask

  // Random particle: lifetimes short, long or zero; ages near the lifetime or anywhere.
  task automatic random_particle();
    logic [prc_pkg::AGE_W-1:0] age;
    logic [prc_pkg::LIFE_W-1:0] life;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) life = '0;
    else if (r < 25) life = 16'($urandom_range(1, 16));
    else life = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) age = '0;
    else if (r < 35) age = life + 16'($urandom_range(0, 2)) - 16'd1;
    else if (r < 50) age = 16'($urandom_range(0, 64));
    else age = 16'($urandom);
    send_particle(age, life);
  endtask

  initial begin
    ramp_sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Plain start-to-end ramp, channels rising and falling across the full range.
    write_reg(prc_pkg::REG_START_HEAD, 32'h0000_0000);
    write_reg(prc_pkg::REG_END_HEAD, 32'hFFFF_FFFF);
    write_reg(prc_pkg::REG_START_TAIL, 32'hFF00_FF00);
    write_reg(prc_pkg::REG_END_TAIL, 32'h00FF_00FF);
    write_reg(prc_pkg::REG_MID_HEAD, 32'h1234_5678);
    write_reg(prc_pkg::REG_MID_TAIL, 32'hFEDC_BA98);
    write_reg(prc_pkg::REG_MID_POINT, prc_pkg::DATA_W'(MID_NONE));
    settings++;
    send_particle(16'd0, 16'd1);
    send_particle(16'd0, 16'd0);
    send_particle(16'hFFFF, 16'hFFFF);
    send_particle(16'hFFFF, 16'd1);
    send_particle(16'd1, 16'hFFFF);
    send_particle(16'h8000, 16'hFFFF);
    send_particle(16'd12345, 16'd0);
    send_particle(16'd100, 16'd200);
    send_particle(16'hFFFE, 16'hFFFF);
    drain();

    // A mid point at zero puts every position in the upper half.
    write_reg(prc_pkg::REG_MID_POINT, 32'h0);
    settings++;
    send_particle(16'd0, 16'd10);
    send_particle(16'd5, 16'd10);
    send_particle(16'd10, 16'd10);
    send_particle(16'hFFFF, 16'd2);
    drain();

    // Mid point at its top, then in the middle.
    write_reg(prc_pkg::REG_MID_POINT, 32'h0_FFFF);
    settings++;
    send_particle(16'hFFFE, 16'hFFFF);
    send_particle(16'hFFFF, 16'hFFFF);
    send_particle(16'd0, 16'd7);
    send_particle(16'd30000, 16'hFFFF);
    drain();
    write_reg(prc_pkg::REG_MID_POINT, 32'h0_8000);
    settings++;
    send_particle(16'd1, 16'd2);
    send_particle(16'd0, 16'd2);
    send_particle(16'd3, 16'd4);
    send_particle(16'd40000, 16'd60000);
    drain();

    // A negative mid point other than minus one, and a write past the register file.
    write_reg(prc_pkg::REG_MID_POINT, 32'h1_0000);
    write_reg(REG_UNUSED, 32'h0_4000);
    settings++;
    send_particle(16'd1, 16'd3);
    send_particle(16'd2, 16'd3);
    send_particle(16'd7, 16'd9);
    drain();

    // Random phases, one of them with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_setting();
      quiet = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) random_particle();
      drain();
      quiet = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Checked %0d particles over %0d ramp settings (%0d register writes).",
             ramp_sb.particles, settings, ramp_sb.reg_writes);
    $display("Mid points covered: none, negative, zero, top and random; zero and late ages.");
    if (ramp_sb.errors == 0 && ramp_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
